// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the level meter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define LVM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define LVM_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/lvm_pkg.sv -----
// ----------------------------------------------------------------------------
// Level meter package
// Payload types, register indexes, reset values and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lvm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int SUM_W       = 42;
   localparam int COUNT_W     = 17;
   localparam int QUOT_W      = 32;
   localparam int REM_W       = 18;
   localparam int ROOT_W      = 16;
   localparam int DIV_STEPS   = SUM_W;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int CSR_W       = 17;

   localparam logic [15:0] UNITY_Q15 = 16'd32768;
   localparam logic [16:0] UNITY_Q16 = 17'd65536;

   localparam logic [15:0] CLIP_THRESHOLD_RESET = 16'd32440;
   localparam logic [16:0] PEAK_DECAY_RESET     = 17'd65208;
   localparam logic [15:0] RMS_FLOOR_RESET      = 16'd1;

   localparam logic [1:0] CSR_CLIP_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_PEAK_DECAY     = 2'd1;
   localparam logic [1:0] CSR_RMS_FLOOR      = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          block_end;
   } lvm_req_type;

   typedef struct packed {
      logic [15:0] rms_level;
      logic [15:0] peak_level;
      logic        clip_seen;
      logic [15:0] min_rms;
      logic [15:0] max_rms;
   } lvm_rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
      logic [15:0]        peak;
      logic               clip;
   } lvm_block_type;

   typedef struct packed {
      logic [15:0] clip_threshold;
      logic [16:0] peak_decay;
      logic [15:0] rms_floor;
   } lvm_cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_SQRT,
      BK_MUL,
      BK_DONE
   } lvm_back_state_type;

endpackage

`default_nettype wire

// ----- rtl/lvm_front.sv -----
// ----------------------------------------------------------------------------
// Level meter front end
// Accumulates sum of squares, peak, clip per block; a sample a cycle on accept.
// ----------------------------------------------------------------------------
`default_nettype none

module lvm_front
   import lvm_pkg::*;
#(
   parameter int MAX_BLOCK = 4096
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire lvm_req_type   req,
   input  wire logic [15:0]   clip_threshold,
   output logic               blk_push,
   output lvm_block_type      blk_data
);

`include "assert_macros.svh"

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      peak_ff, peak_in;
   logic             clip_ff, clip_in;

   logic [15:0]      raw;
   logic [15:0]      mag;
   logic [31:0]      sq;
   logic [SUM_W:0]   sum_wide;
   logic [SUM_W-1:0] sum_sat;
   logic [CNT_W-1:0] count_nx;
   logic [15:0]      peak_nx;
   logic [15:0]      thr;
   logic             clip_nx;
   logic             close;

   always_comb begin
      raw      = req.sample;
      mag      = raw[15] ? (~raw + 16'd1) : raw;
      sq       = 32'(mag) * 32'(mag);
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(sq);
      sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      count_nx = count_ff + CNT_W'(1);
      peak_nx  = (mag > peak_ff) ? mag : peak_ff;
      thr      = (clip_threshold > UNITY_Q15) ? UNITY_Q15 : clip_threshold;
      clip_nx  = clip_ff | (mag >= thr);
      close    = req.block_end || (count_nx == CNT_W'(MAX_BLOCK));

      sum_in   = sum_ff;
      count_in = count_ff;
      peak_in  = peak_ff;
      clip_in  = clip_ff;
      blk_push = 1'b0;

      blk_data.sum   = sum_sat;
      blk_data.count = COUNT_W'(count_nx);
      blk_data.peak  = peak_nx;
      blk_data.clip  = clip_nx;

      if (accept) begin
         if (close) begin
            blk_push = 1'b1;
            sum_in   = '0;
            count_in = '0;
            peak_in  = '0;
            clip_in  = 1'b0;
         end else begin
            sum_in   = sum_sat;
            count_in = count_nx;
            peak_in  = peak_nx;
            clip_in  = clip_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         peak_ff  <= '0;
         clip_ff  <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         peak_ff  <= peak_in;
         clip_ff  <= clip_in;
      end
   end

   `LVM_ASSERT(a_count_below_max, clock, reset, count_ff < CNT_W'(MAX_BLOCK), "block count reached limit")

endmodule

`default_nettype wire

// ----- rtl/lvm_queue.sv -----
// ----------------------------------------------------------------------------
// Level meter block queue
// Short FIFO of closed-block records between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lvm_queue
   import lvm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire lvm_block_type push_data,
   input  wire logic          pop,
   output logic               full,
   output logic               empty,
   output lvm_block_type      pop_data
);

`include "assert_macros.svh"

   lvm_block_type       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   fill_ff, fill_in;
   logic                do_push;
   logic                do_pop;

   always_comb begin
      full      = (fill_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
      empty     = (fill_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      pop_data  = entry_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QUEUE_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   `LVM_ASSERT(a_no_push_full, clock, reset, push |-> !full, "block record pushed into full queue")
   `LVM_ASSERT(a_fill_bound, clock, reset, fill_ff <= (QUEUE_AW + 1)'(QUEUE_DEPTH), "queue fill out of range")

endmodule

`default_nettype wire

// ----- rtl/lvm_back.sv -----
// ----------------------------------------------------------------------------
// Level meter back end
// Per-block divide, square root, peak decay and min/max update.
// ----------------------------------------------------------------------------
`default_nettype none

module lvm_back
   import lvm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          blk_empty,
   input  wire lvm_block_type blk_data,
   output logic               blk_pop,
   input  wire lvm_cfg_type   cfg,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output lvm_rsp_type        rsp_data
);

`include "assert_macros.svh"

   lvm_back_state_type state_ff, state_in;

   logic [SUM_W-1:0]   dvd_ff, dvd_in;
   logic [COUNT_W-1:0] dsr_ff, dsr_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [15:0]        bpeak_ff, bpeak_in;
   logic               bclip_ff, bclip_in;
   logic [32:0]        prod_ff, prod_in;

   logic [15:0]        peak_hold_ff, peak_hold_in;
   logic               clip_sticky_ff, clip_sticky_in;
   logic [15:0]        lowest_ff, lowest_in;
   logic [15:0]        highest_ff, highest_in;

   logic               out_valid_ff, out_valid_in;
   lvm_rsp_type        out_ff, out_in;

   logic [REM_W-1:0]   div_sh;
   logic [REM_W-1:0]   div_dsr;
   logic               div_ge;
   logic [REM_W-1:0]   sq_sh;
   logic [REM_W-1:0]   sq_trial;
   logic               sq_ge;
   logic [16:0]        dec;
   logic [15:0]        decayed;
   logic [15:0]        peak_new;
   logic               commit;

   always_comb begin
      div_sh   = {rem_ff[REM_W-2:0], dvd_ff[SUM_W-1]};
      div_dsr  = REM_W'(dsr_ff);
      div_ge   = (div_sh >= div_dsr);
      sq_sh    = {rem_ff[REM_W-3:0], quot_ff[QUOT_W-1 -: 2]};
      sq_trial = {root_ff, 2'b01};
      sq_ge    = (sq_sh >= sq_trial);
      dec      = (cfg.peak_decay > UNITY_Q16) ? UNITY_Q16 : cfg.peak_decay;
      decayed  = prod_ff[31:16];
      peak_new = (bpeak_ff > decayed) ? bpeak_ff : decayed;

      state_in       = state_ff;
      dvd_in         = dvd_ff;
      dsr_in         = dsr_ff;
      quot_in        = quot_ff;
      rem_in         = rem_ff;
      root_in        = root_ff;
      step_in        = step_ff;
      bpeak_in       = bpeak_ff;
      bclip_in       = bclip_ff;
      prod_in        = prod_ff;
      peak_hold_in   = peak_hold_ff;
      clip_sticky_in = clip_sticky_ff;
      lowest_in      = lowest_ff;
      highest_in     = highest_ff;
      out_in         = out_ff;
      blk_pop        = 1'b0;
      commit         = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!blk_empty) begin
               blk_pop  = 1'b1;
               dvd_in   = blk_data.sum;
               dsr_in   = blk_data.count;
               bpeak_in = blk_data.peak;
               bclip_in = blk_data.clip;
               quot_in  = '0;
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            rem_in  = div_ge ? (div_sh - div_dsr) : div_sh;
            dvd_in  = {dvd_ff[SUM_W-2:0], 1'b0};
            quot_in = {quot_ff[QUOT_W-2:0], div_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               rem_in   = '0;
               step_in  = '0;
               state_in = BK_SQRT;
            end
         end
         BK_SQRT: begin
            rem_in  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
            root_in = {root_ff[ROOT_W-2:0], sq_ge};
            quot_in = {quot_ff[QUOT_W-3:0], 2'b00};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            prod_in  = 33'(peak_hold_ff) * 33'(dec);
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               commit         = 1'b1;
               peak_hold_in   = peak_new;
               clip_sticky_in = clip_sticky_ff | bclip_ff;
               if ((root_ff > cfg.rms_floor) && (root_ff < lowest_ff)) begin
                  lowest_in = root_ff;
               end
               if (root_ff > highest_ff) begin
                  highest_in = root_ff;
               end
               out_in.rms_level  = root_ff;
               out_in.peak_level = peak_new;
               out_in.clip_seen  = clip_sticky_ff | bclip_ff;
               out_in.min_rms    = ((root_ff > cfg.rms_floor) && (root_ff < lowest_ff))
                                   ? root_ff : lowest_ff;
               out_in.max_rms    = (root_ff > highest_ff) ? root_ff : highest_ff;
               state_in          = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (commit) begin
         out_valid_in = 1'b1;
      end

      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         step_ff        <= '0;
         peak_hold_ff   <= '0;
         clip_sticky_ff <= 1'b0;
         lowest_ff      <= UNITY_Q15;
         highest_ff     <= '0;
      end else begin
         out_valid_ff   <= out_valid_in;
         step_ff        <= step_in;
         peak_hold_ff   <= peak_hold_in;
         clip_sticky_ff <= clip_sticky_in;
         lowest_ff      <= lowest_in;
         highest_ff     <= highest_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      dsr_ff   <= dsr_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      bpeak_ff <= bpeak_in;
      bclip_ff <= bclip_in;
      prod_ff  <= prod_in;
      out_ff   <= out_in;
   end

   `LVM_ASSERT(a_rms_range, clock, reset, (state_ff == BK_DONE) |-> (root_ff <= UNITY_Q15), "block RMS above full scale")
   `LVM_ASSERT(a_pop_idle_only, clock, reset, blk_pop |-> (state_ff == BK_IDLE && !blk_empty), "block record taken while busy")

endmodule

`default_nettype wire

// ----- rtl/audio_block_level_meter_unit.sv -----
// Throughput: one sample per cycle while req_full is low; the back end finishes
//   one block (42-step divider, 16-step square root, multiply, commit) before it
//   takes the next, with two closed blocks queued.
// Reset: synchronous, active high; clears accumulators, queue and result, sets
//   min RMS to 1.0 and the registers to their defaults.
// ----------------------------------------------------------------------------
// Audio block level meter
// Block RMS, decaying peak hold, sticky clip and min/max RMS per block.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_block_level_meter_unit
   import lvm_pkg::*;
#(
   parameter int MAX_BLOCK = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire lvm_req_type      req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output lvm_rsp_type           rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   lvm_cfg_type   cfg_ff, cfg_in;
   logic          accept;
   logic          blk_push;
   lvm_block_type blk_push_data;
   logic          blk_pop;
   logic          blk_full;
   logic          blk_empty;
   lvm_block_type blk_pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CLIP_THRESHOLD: cfg_in.clip_threshold = csr_wdata[15:0];
            CSR_PEAK_DECAY:     cfg_in.peak_decay     = csr_wdata[16:0];
            CSR_RMS_FLOOR:      cfg_in.rms_floor      = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
      req_full = blk_full;
      accept   = req_push && !blk_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_threshold <= CLIP_THRESHOLD_RESET;
         cfg_ff.peak_decay     <= PEAK_DECAY_RESET;
         cfg_ff.rms_floor      <= RMS_FLOOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lvm_front #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req            (req_data),
      .clip_threshold (cfg_ff.clip_threshold),
      .blk_push       (blk_push),
      .blk_data       (blk_push_data)
   );

   lvm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (blk_push),
      .push_data (blk_push_data),
      .pop       (blk_pop),
      .full      (blk_full),
      .empty     (blk_empty),
      .pop_data  (blk_pop_data)
   );

   lvm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .blk_empty (blk_empty),
      .blk_data  (blk_pop_data),
      .blk_pop   (blk_pop),
      .cfg       (cfg_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
